// ===== rtl/sme_pkg.sv =====
package sme_pkg;

  // Element and index widths.
  localparam int ELEM_W  = 32;
  localparam int IDX_W   = 3;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int SEL_W   = 2;
  localparam int ORDER_W = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Largest matrix order the stores hold.
  localparam logic [ORDER_W-1:0] MAX_ORDER   = 4'd8;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

  // Operand select codes.
  localparam logic [SEL_W-1:0] SEL_A = 2'd0;
  localparam logic [SEL_W-1:0] SEL_B = 2'd1;
  localparam logic [SEL_W-1:0] SEL_C = 2'd2;
  localparam logic [SEL_W-1:0] SEL_D = 2'd3;

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_ORDER  = 1'b0;
  localparam logic REG_ADDEND = 1'b1;

  // Configuration as seen by the compute core.
  typedef struct packed {
    logic [IDX_W-1:0]  nm1;     // order minus one, already clamped
    logic [ELEM_W-1:0] addend;  // diagonal addend k
  } sme_cfg_t;

  // Store address of element (row, col), row-major with a fixed side of eight.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    return {row, col};
  endfunction

endpackage

// ===== rtl/sme_ifs.sv =====
// Input channel: one matrix element per beat.
interface sme_in_if;
  logic                        valid;
  logic                        ready;
  logic [sme_pkg::SEL_W-1:0]   matrix_select;
  logic [sme_pkg::IDX_W-1:0]   row_index;
  logic [sme_pkg::IDX_W-1:0]   col_index;
  logic signed [sme_pkg::ELEM_W-1:0] element_value;
  logic                        start_compute;

  modport source (output valid, matrix_select, row_index, col_index, element_value,
                  start_compute, input ready);
  modport sink (input valid, matrix_select, row_index, col_index, element_value,
                start_compute, output ready);
endinterface

// Result channel: one result element per beat.
interface sme_out_if;
  logic                        valid;
  logic                        ready;
  logic [sme_pkg::IDX_W-1:0]   out_row;
  logic [sme_pkg::IDX_W-1:0]   out_col;
  logic signed [sme_pkg::ELEM_W-1:0] out_value;
  logic                        out_last;

  modport source (output valid, out_row, out_col, out_value, out_last, input ready);
  modport sink (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

// ===== rtl/sme_ram.sv =====
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sme_cfg.sv =====
module sme_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sme_pkg::PADDR_W-1:0]   paddr,
  input  logic [sme_pkg::PDATA_W-1:0]   pwdata,
  output logic [sme_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output sme_pkg::sme_cfg_t             cfg
);

  logic [sme_pkg::ORDER_W-1:0] order_r;
  logic [sme_pkg::ELEM_W-1:0]  addend_r;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= sme_pkg::ORDER_RESET;
      addend_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        sme_pkg::REG_ORDER:  order_r  <= pwdata[sme_pkg::ORDER_W-1:0];
        sme_pkg::REG_ADDEND: addend_r <= pwdata[sme_pkg::ELEM_W-1:0];
        default:             order_r  <= order_r;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[2])
      sme_pkg::REG_ORDER:  prdata = {{(sme_pkg::PDATA_W-sme_pkg::ORDER_W){1'b0}}, order_r};
      sme_pkg::REG_ADDEND: prdata = addend_r;
      default:             prdata = '0;
    endcase
  end

  // Order zero acts as one, orders above the store side saturate.
  always_comb begin
    priority if (order_r == '0) begin
      cfg.nm1 = '0;
    end else if (order_r > sme_pkg::MAX_ORDER) begin
      cfg.nm1 = sme_pkg::IDX_W'(sme_pkg::MAX_ORDER - 4'd1);
    end else begin
      cfg.nm1 = sme_pkg::IDX_W'(order_r - 4'd1);
    end
    cfg.addend = addend_r;
  end

endmodule

// ===== rtl/sme_core.sv =====
module sme_core (
  input  logic              clk,
  input  logic              rst_n,
  input  sme_pkg::sme_cfg_t cfg,
  sme_in_if.sink            in_ch,
  sme_out_if.source         out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  localparam int EW = sme_pkg::ELEM_W;
  localparam int IW = sme_pkg::IDX_W;
  localparam int AW = sme_pkg::ADDR_W;

  logic [1:0]    state_r, state_nxt;
  logic          phase_r, phase_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, t_r, t_nxt;

  logic          in_fire, issue, pipe_empty, last_elem, next_phase;
  logic [AW-1:0] ld_addr, row_addr, col_addr, diag_addr;
  logic [EW-1:0] a_q, b_q, c_q, d_q, w_q;

  // Read stage (memory data valid).
  logic          s1_v_r, s1_first_r, s1_last_r, s1_diag_r, s1_phase_r;
  logic [IW-1:0] s1_i_r, s1_j_r;
  logic [EW-1:0] mul_x, mul_y, extra;

  // Product stage.
  logic          s2_v_r, s2_first_r, s2_last_r, s2_phase_r;
  logic [IW-1:0] s2_i_r, s2_j_r;
  logic [EW-1:0] prod_r, extra_r;

  // Accumulator and output register.
  logic [EW-1:0] acc_r, acc_sum;
  logic          done, we_w;
  logic          out_valid_r;
  logic [IW-1:0] out_row_r, out_col_r;
  logic [EW-1:0] out_value_r;
  logic          out_last_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign ld_addr  = sme_pkg::cell_addr(in_ch.row_index, in_ch.col_index);
  assign issue    = (state_r == ST_ISSUE);

  // Operand addresses for element (i, j), term t.
  assign row_addr  = sme_pkg::cell_addr(i_r, t_r);
  assign col_addr  = sme_pkg::cell_addr(j_r, t_r);
  assign diag_addr = sme_pkg::cell_addr(i_r, j_r);

  // Operand stores, written by load beats.
  sme_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram_a (
    .clk, .we(in_fire && in_ch.matrix_select == sme_pkg::SEL_A), .waddr(ld_addr),
    .wdata(in_ch.element_value), .raddr(diag_addr), .rdata(a_q)
  );
  sme_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram_b (
    .clk, .we(in_fire && in_ch.matrix_select == sme_pkg::SEL_B), .waddr(ld_addr),
    .wdata(in_ch.element_value), .raddr(row_addr), .rdata(b_q)
  );
  sme_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram_c (
    .clk, .we(in_fire && in_ch.matrix_select == sme_pkg::SEL_C), .waddr(ld_addr),
    .wdata(in_ch.element_value), .raddr(col_addr), .rdata(c_q)
  );
  sme_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram_d (
    .clk, .we(in_fire && in_ch.matrix_select == sme_pkg::SEL_D), .waddr(ld_addr),
    .wdata(in_ch.element_value), .raddr(col_addr), .rdata(d_q)
  );

  // Work store holds A + B*C^T + k*I between the two passes.
  sme_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram_w (
    .clk, .we(we_w), .waddr(sme_pkg::cell_addr(s2_i_r, s2_j_r)),
    .wdata(acc_sum), .raddr(row_addr), .rdata(w_q)
  );

  // Sequencer: walks (i, j) per pass and t within each element.
  assign pipe_empty = !s1_v_r && !s2_v_r;
  assign last_elem  = (i_r == cfg.nm1) && (j_r == cfg.nm1);
  assign next_phase = last_elem ? 1'b1 : phase_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    t_nxt     = t_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_ch.start_compute) begin
          state_nxt = ST_ISSUE;
          phase_nxt = 1'b0;
          i_nxt     = '0;
          j_nxt     = '0;
          t_nxt     = '0;
        end
      end
      ST_ISSUE: begin
        if (t_r == cfg.nm1) begin
          t_nxt     = '0;
          state_nxt = ST_WAIT;
        end else begin
          t_nxt = t_r + 1'b1;
        end
      end
      ST_WAIT: begin
        // Wait for the element to retire; the second pass also needs a free
        // output register before it starts the next element.
        if (pipe_empty) begin
          if (last_elem && phase_r) begin
            state_nxt = ST_IDLE;
          end else if (!next_phase || !out_valid_r) begin
            state_nxt = ST_ISSUE;
            phase_nxt = next_phase;
            if (last_elem) begin
              i_nxt = '0;
              j_nxt = '0;
            end else if (j_r == cfg.nm1) begin
              i_nxt = i_r + 1'b1;
              j_nxt = '0;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      t_r     <= t_nxt;
    end
  end

  // Read stage tags follow the memory latency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
    end
    s1_first_r <= (t_r == '0);
    s1_last_r  <= (t_r == cfg.nm1);
    s1_diag_r  <= (i_r == j_r);
    s1_phase_r <= phase_r;
    s1_i_r     <= i_r;
    s1_j_r     <= j_r;
  end

  // Operand pick and the accumulator seed for the first pass.
  assign mul_x = s1_phase_r ? w_q : b_q;
  assign mul_y = s1_phase_r ? d_q : c_q;
  assign extra = s1_phase_r ? '0 : (a_q + (s1_diag_r ? cfg.addend : '0));

  // Product stage: low word of the product is all the result needs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    prod_r     <= EW'(mul_x * mul_y);
    extra_r    <= extra;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_phase_r <= s1_phase_r;
    s2_i_r     <= s1_i_r;
    s2_j_r     <= s1_j_r;
  end

  // Accumulate; the first term starts from the seed instead of the old sum.
  assign acc_sum = (s2_first_r ? extra_r : acc_r) + prod_r;
  assign done    = s2_v_r && s2_last_r;
  assign we_w    = done && !s2_phase_r;

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      acc_r <= acc_sum;
    end
  end

  // Output register, loaded by finished elements of the second pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done && s2_phase_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (done && s2_phase_r) begin
      out_row_r   <= s2_i_r;
      out_col_r   <= s2_j_r;
      out_value_r <= acc_sum;
      out_last_r  <= (s2_i_r == cfg.nm1) && (s2_j_r == cfg.nm1);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.out_last  = out_last_r;

endmodule

// ===== rtl/square_matrix_expression_engine.sv =====
// Computes R = (A + B*C^T + k*I) * D^T on signed 32-bit square matrices of
// order 1..8 (register matrix_order; zero acts as one, above eight saturates),
// with every sum and product wrapped to 32 bits. Load beats write one element
// of A, B, C or D each cycle while input ready is high; the beat with
// start_compute set is stored first, then the engine computes and input
// ready stays low until the last result is in the output register. Each
// result element reads its order terms from the operand memories one per
// cycle through a read, a multiply and an accumulate stage, and the element
// retires before the next starts. The first pass writes A + B*C^T + k*I to
// the work memory, the second streams R row-major, so output stalls lengthen
// a compute. Elements must be loaded before they are used; memories are not
// cleared at reset.
module square_matrix_expression_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  sme_in_if.sink                        in_ch,
  sme_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sme_pkg::PADDR_W-1:0]   paddr,
  input  logic [sme_pkg::PDATA_W-1:0]   pwdata,
  output logic [sme_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  sme_pkg::sme_cfg_t cfg;

  sme_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  sme_core u_core (
    .clk, .rst_n, .cfg, .in_ch, .out_ch
  );

  // The final beat lies on the diagonal at the last row.
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_last) |->
      (out_ch.out_row == cfg.nm1 && out_ch.out_col == cfg.nm1))
    else $error("last result beat not at the bottom-right corner");

  // A start beat closes the input until the compute finishes.
  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.start_compute) |=> !in_ch.ready)
    else $error("input accepted right after a start beat");

  // Result indexes stay within the configured order.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.out_row <= cfg.nm1 && out_ch.out_col <= cfg.nm1))
    else $error("result index beyond the matrix order");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RAND_PHASES = 12;
  localparam int SIDE = 8;

  // One load beat and one result beat as the channels carry them.
  typedef struct packed {
    logic [sme_pkg::SEL_W-1:0]  sel;
    logic [sme_pkg::IDX_W-1:0]  row;
    logic [sme_pkg::IDX_W-1:0]  col;
    logic [sme_pkg::ELEM_W-1:0] value;
    logic                       start;
  } load_t;

  typedef struct packed {
    logic [sme_pkg::IDX_W-1:0]  row;
    logic [sme_pkg::IDX_W-1:0]  col;
    logic [sme_pkg::ELEM_W-1:0] value;
    logic                       last;
  } element_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sme_pkg::PADDR_W-1:0] paddr;
  logic [sme_pkg::PDATA_W-1:0] pwdata;
  logic [sme_pkg::PDATA_W-1:0] prdata;
  logic pready;

  sme_in_if  in_ch();
  sme_out_if out_ch();

  square_matrix_expression_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // Loads waiting to be driven, and result elements still owed by the block.
  load_t    load_backlog[$];
  element_t predicted_elements[$];

  // Mirror of the operand stores, kept at the accepted beats, and of the registers.
  logic [sme_pkg::ELEM_W-1:0]  mat_a[SIDE*SIDE];
  logic [sme_pkg::ELEM_W-1:0]  mat_b[SIDE*SIDE];
  logic [sme_pkg::ELEM_W-1:0]  mat_c[SIDE*SIDE];
  logic [sme_pkg::ELEM_W-1:0]  mat_d[SIDE*SIDE];
  logic [sme_pkg::ORDER_W-1:0] cfg_order = sme_pkg::ORDER_RESET;
  logic [sme_pkg::ELEM_W-1:0]  cfg_addend = '0;

  // Cells the stimulus has queued for loading so far, so no unwritten cell is ever read.
  bit loaded[4][SIDE*SIDE];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  int loads_accepted = 0;
  int computes_started = 0;
  int results_checked = 0;
  int items_queued = 0;
  logic [15:0] orders_seen = '0;
  logic load_taken;

  task automatic log_error(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic int order_in_use(input logic [sme_pkg::ORDER_W-1:0] ord);
    if (ord == 0) return 1;
    if (ord > sme_pkg::MAX_ORDER) return int'(sme_pkg::MAX_ORDER);
    return int'(ord);
  endfunction

  // Store the beat, and on a start beat work out R = (A + B*C^T + k*I) * D^T.
  task automatic apply_load(input load_t it);
    logic [sme_pkg::ADDR_W-1:0] a;
    logic [sme_pkg::ELEM_W-1:0] acc;
    logic [sme_pkg::ELEM_W-1:0] sum_m[SIDE*SIDE];
    element_t e;
    int n;
    a = {it.row, it.col};
    case (it.sel)
      sme_pkg::SEL_A: mat_a[a] = it.value;
      sme_pkg::SEL_B: mat_b[a] = it.value;
      sme_pkg::SEL_C: mat_c[a] = it.value;
      sme_pkg::SEL_D: mat_d[a] = it.value;
    endcase
    if (it.start) begin
      n = order_in_use(cfg_order);
      computes_started++;
      orders_seen[cfg_order] = 1'b1;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          acc = '0;
          for (int t = 0; t < n; t++)
            acc = acc + mat_b[i*SIDE+t] * mat_c[j*SIDE+t];
          acc = acc + mat_a[i*SIDE+j];
          if (i == j)
            acc = acc + cfg_addend;
          sum_m[i*SIDE+j] = acc;
        end
      end
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          acc = '0;
          for (int t = 0; t < n; t++)
            acc = acc + sum_m[i*SIDE+t] * mat_d[j*SIDE+t];
          e.row = sme_pkg::IDX_W'(i);
          e.col = sme_pkg::IDX_W'(j);
          e.value = acc;
          e.last = (i == n - 1) && (j == n - 1);
          predicted_elements.push_back(e);
        end
      end
    end
  endtask

  task automatic check_element(input element_t got);
    element_t want;
    results_checked++;
    if (predicted_elements.size() == 0) begin
      log_error($sformatf("result beat (%0d,%0d) value %h with nothing expected",
                          got.row, got.col, got.value));
    end else begin
      want = predicted_elements.pop_front();
      if (got.row !== want.row)
        log_error($sformatf("row %0d, expected %0d", got.row, want.row));
      if (got.col !== want.col)
        log_error($sformatf("col %0d, expected %0d", got.col, want.col));
      if (got.value !== want.value)
        log_error($sformatf("element (%0d,%0d): value %h, expected %h",
                            want.row, want.col, got.value, want.value));
      if (got.last !== want.last)
        log_error($sformatf("element (%0d,%0d): last %b, expected %b",
                            want.row, want.col, got.last, want.last));
    end
  endtask

  // Monitor: both channels are sampled at the rising edge.
  always @(posedge clk) begin
    load_t    ld;
    element_t res;
    if (!rst_n) begin
      load_taken <= 1'b0;
    end else begin
      load_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        ld.sel = in_ch.matrix_select;
        ld.row = in_ch.row_index;
        ld.col = in_ch.col_index;
        ld.value = in_ch.element_value;
        ld.start = in_ch.start_compute;
        loads_accepted++;
        apply_load(ld);
      end
      if (out_ch.valid && out_ch.ready) begin
        res.row = out_ch.out_row;
        res.col = out_ch.out_col;
        res.value = out_ch.out_value;
        res.last = out_ch.out_last;
        check_element(res);
      end
    end
  end

  // Driver: a new beat goes out once the previous one was taken.
  always @(negedge clk) begin
    load_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || load_taken) begin
      if (load_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = load_backlog.pop_front();
        in_ch.matrix_select <= it.sel;
        in_ch.row_index <= it.row;
        in_ch.col_index <= it.col;
        in_ch.element_value <= it.value;
        in_ch.start_compute <= it.start;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT)
      @(posedge clk) cycle_count++;
    $display("Timeout after %0d cycles, %0d elements still expected",
             cycle_count, predicted_elements.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [sme_pkg::ELEM_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      4: return sme_pkg::ELEM_W'($urandom_range(15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input logic [sme_pkg::SEL_W-1:0] sel, input int row,
                           input int col, input logic [sme_pkg::ELEM_W-1:0] value,
                           input logic start);
    load_t it;
    it.sel = sel;
    it.row = sme_pkg::IDX_W'(row);
    it.col = sme_pkg::IDX_W'(col);
    it.value = value;
    it.start = start;
    load_backlog.push_back(it);
    loaded[sel][{it.row, it.col}] = 1'b1;
    items_queued++;
  endtask

  // One well-formed sequence: fill or refresh the active corner of every
  // operand, sprinkle stray loads anywhere, shuffle, and finish with a start.
  task automatic queue_compute(input int n, input int reload_pct, input int noise);
    load_t seq[$];
    load_t it;
    int j;
    for (int m = 0; m < 4; m++)
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          if (!loaded[m][r*SIDE+c] || $urandom_range(99) < reload_pct) begin
            it.sel = sme_pkg::SEL_W'(m);
            it.row = sme_pkg::IDX_W'(r);
            it.col = sme_pkg::IDX_W'(c);
            it.value = pick_value();
            it.start = 1'b0;
            seq.push_back(it);
          end
    for (int k = 0; k < noise; k++) begin
      it.sel = sme_pkg::SEL_W'($urandom_range(3));
      it.row = sme_pkg::IDX_W'($urandom_range(7));
      it.col = sme_pkg::IDX_W'($urandom_range(7));
      it.value = pick_value();
      it.start = 1'b0;
      seq.push_back(it);
    end
    for (int k = seq.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      it = seq[k];
      seq[k] = seq[j];
      seq[j] = it;
    end
    foreach (seq[k])
      push_item(seq[k].sel, int'(seq[k].row), int'(seq[k].col), seq[k].value, 1'b0);
    push_item(sme_pkg::SEL_W'($urandom_range(3)), int'($urandom_range(7)),
              int'($urandom_range(7)), pick_value(), 1'b1);
  endtask

  // Wait until every queued beat is taken and every result has arrived.
  task automatic wait_idle();
    while (load_backlog.size() > 0 || in_ch.valid || predicted_elements.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic [sme_pkg::PDATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == sme_pkg::REG_ORDER)
      cfg_order = data[sme_pkg::ORDER_W-1:0];
    else
      cfg_addend = data;
  endtask

  initial begin
    logic [sme_pkg::ELEM_W-1:0] corner_vals[5];
    int k;
    int n;
    int order_w;
    int reps;
    logic [sme_pkg::ELEM_W-1:0] addend_w;

    corner_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1};
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.matrix_select = sme_pkg::SEL_A;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.element_value = '0;
    in_ch.start_compute = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 16;
    recv_idle_pct = 52;

    // Order one, most negative addend, extreme element values.
    write_reg(sme_pkg::REG_ORDER, 32'd1);
    write_reg(sme_pkg::REG_ADDEND, 32'h8000_0000);
    push_item(sme_pkg::SEL_A, 0, 0, 32'h7fff_ffff, 1'b0);
    push_item(sme_pkg::SEL_B, 0, 0, 32'h8000_0000, 1'b0);
    push_item(sme_pkg::SEL_C, 0, 0, 32'hffff_ffff, 1'b0);
    push_item(sme_pkg::SEL_D, 0, 0, 32'h7fff_ffff, 1'b1);
    wait_idle();

    // Order zero acts as one; loads beyond the order are stored but unused.
    write_reg(sme_pkg::REG_ORDER, 32'd0);
    write_reg(sme_pkg::REG_ADDEND, 32'h7fff_ffff);
    push_item(sme_pkg::SEL_A, 7, 7, 32'hffff_ffff, 1'b0);
    push_item(sme_pkg::SEL_D, 0, 0, 32'hffff_ffff, 1'b0);
    push_item(sme_pkg::SEL_C, 7, 0, 32'h0, 1'b0);
    push_item(sme_pkg::SEL_B, 0, 0, 32'h1, 1'b1);
    wait_idle();

    // Order two, zero addend; the start beat loads into A.
    write_reg(sme_pkg::REG_ORDER, 32'd2);
    write_reg(sme_pkg::REG_ADDEND, 32'h0);
    k = 0;
    for (int m = 3; m >= 0; m--)
      for (int r = 0; r < 2; r++)
        for (int c = 0; c < 2; c++)
          if (r != 0 || c != 0) begin
            push_item(sme_pkg::SEL_W'(m), r, c, corner_vals[k % 5],
                      (m == 0) && (r == 1) && (c == 1));
            k++;
          end
    wait_idle();

    // Random phases with a fresh setting each; idling changes by thirds.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < RAND_PHASES / 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 52;
      end else if (p < 2 * RAND_PHASES / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 5)
        order_w = $urandom_range(15, 9);
      else if (p == 10)
        order_w = int'(sme_pkg::MAX_ORDER);
      else if (p == 2)
        order_w = 0;
      else
        order_w = $urandom_range(4, 1);
      if (p == 1)
        addend_w = 32'h8000_0000;
      else if (p == 7)
        addend_w = 32'h7fff_ffff;
      else if (p == 3)
        addend_w = 32'h0;
      else
        addend_w = $urandom;
      write_reg(sme_pkg::REG_ORDER, sme_pkg::PDATA_W'(order_w));
      write_reg(sme_pkg::REG_ADDEND, addend_w);
      n = order_in_use(sme_pkg::ORDER_W'(order_w));
      reps = (p % 4 == 1) ? 2 : 1;
      for (int r = 0; r < reps; r++) begin
        queue_compute(n, (n > 4) ? 0 : 5, $urandom_range(1));
        // Now and then the sender holds back until the matrix has drained.
        if (r == 0 && (p == 0 || $urandom_range(3) == 0))
          wait_idle();
      end
      wait_idle();
    end

    if (predicted_elements.size() != 0)
      log_error($sformatf("%0d result elements never arrived", predicted_elements.size()));
    $display("Queued %0d load beats, %0d taken, over %0d computes; order settings: %b",
             items_queued, loads_accepted, computes_started, orders_seen);
    $display("Checked %0d result beats with %0d errors", results_checked, error_count);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sme_pkg.sv
rtl/sme_ifs.sv
rtl/sme_ram.sv
rtl/sme_cfg.sv
rtl/sme_core.sv
rtl/square_matrix_expression_engine.sv
tb/testbench.sv
